// ===== rtl/trrf_pkg.sv =====
package trrf_pkg;

  localparam int SLOTS_DEF = 10;
  localparam int BOXES_DEF = 3;
  localparam int MAX_BOXES = 8;
  localparam int ID_W      = 4;
  localparam int COORD_W   = 12;
  localparam int WID_W     = 8;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HELD = 2'd1,
    MODE_PASS = 2'd2
  } mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] xlo;
    logic [COORD_W-1:0] xhi;
    logic [COORD_W-1:0] ylo;
    logic [COORD_W-1:0] yhi;
    logic [WID_W-1:0]   wlo;
    logic [WID_W-1:0]   whi;
  } box_t;

  // rows past the third are empty (low above high)
  localparam box_t BOX_TAB [MAX_BOXES] = '{
    '{12'd1086, 12'd1154, 12'd2905, 12'd3088, 8'd62, 8'd85},
    '{12'd800,  12'd1440, 12'd200,  12'd600,  8'd70, 8'd255},
    '{12'd330,  12'd626,  12'd2918, 12'd3022, 8'd68, 8'd108},
    '{12'd1, 12'd0, 12'd1, 12'd0, 8'd1, 8'd0},
    '{12'd1, 12'd0, 12'd1, 12'd0, 8'd1, 8'd0},
    '{12'd1, 12'd0, 12'd1, 12'd0, 8'd1, 8'd0},
    '{12'd1, 12'd0, 12'd1, 12'd0, 8'd1, 8'd0},
    '{12'd1, 12'd0, 12'd1, 12'd0, 8'd1, 8'd0}
  };

  // stored slot word: mode in the top bits, held position below
  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  function automatic logic in_any_box(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [WID_W-1:0] w,
                                      input int nbox);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (i < nbox &&
          x >= BOX_TAB[i].xlo && x <= BOX_TAB[i].xhi &&
          y >= BOX_TAB[i].ylo && y <= BOX_TAB[i].yhi &&
          w >= BOX_TAB[i].wlo && w <= BOX_TAB[i].whi) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/touch_region_restrain_filter.sv =====
// Path: an accepted input beat goes through the stage-1 register, then the output register.
// Throughput: one beat per cycle without back-pressure; slot-state RAM read on accept,
//   written back as the beat leaves stage 1, with a bypass register for back-to-back hits.
// Reset (rst, synchronous): all slots read as idle at once via per-slot valid flops;
//   pipeline and output are emptied. Held positions are not cleared.
module touch_region_restrain_filter #(
  parameter int SLOTS = trrf_pkg::SLOTS_DEF,
  parameter int BOXES = trrf_pkg::BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // finger_id[3:0], x[15:4], y[27:16], width[35:28], zero pad
  input  logic        s_tuser,   // action: 0 report, 1 release
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot[3:0], zero pad
  output logic        m_tuser    // report: 1 forward, 0 suppress
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [trrf_pkg::ID_W:0] SLOTS_V = (trrf_pkg::ID_W + 1)'(SLOTS);

  // stage-1 beat: decoded fields plus the box test done at accept time
  typedef struct packed {
    logic                          release_b;
    logic [trrf_pkg::ID_W-1:0]     id;
    logic [trrf_pkg::COORD_W-1:0]  x;
    logic [trrf_pkg::COORD_W-1:0]  y;
    logic                          hit;
  } beat_t;

  logic                          in_accept;
  beat_t                         s1;
  logic                          s1_valid;
  logic                          advance;

  logic [trrf_pkg::COORD_W-1:0]  in_x;
  logic [trrf_pkg::COORD_W-1:0]  in_y;
  logic [trrf_pkg::WID_W-1:0]    in_w;

  // slot RAM ports
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  trrf_pkg::slot_rec_t           wr_rec;
  logic [trrf_pkg::REC_W-1:0]    rd_data;

  // per-slot written flags; unwritten slots read as idle
  logic [SLOTS-1:0]              seen;

  // bypass of the last write
  logic                          fwd_valid;
  logic [AW-1:0]                 fwd_addr;
  trrf_pkg::slot_rec_t           fwd_rec;

  trrf_pkg::slot_rec_t           cur_rec;
  logic [1:0]                    cur_mode;
  logic                          s1_in_range;
  logic [AW-1:0]                 s1_addr;
  logic                          rep;

  assign in_x = s_tdata[15:4];
  assign in_y = s_tdata[27:16];
  assign in_w = s_tdata[35:28];

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || advance;
  assign in_accept = s_tvalid && s_tready;

  // ---------------- stage 0: accept, read slot RAM, test boxes ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1.release_b <= s_tuser;
      s1.id        <= s_tdata[3:0];
      s1.x         <= in_x;
      s1.y         <= in_y;
      s1.hit       <= trrf_pkg::in_any_box(in_x, in_y, in_w, BOXES);
    end
  end

  trrf_ram #(
    .WIDTH (trrf_pkg::REC_W),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_rec),
    .re    (in_accept),
    .raddr (s_tdata[AW-1:0]),
    .rdata (rd_data)
  );

  // ---------------- stage 1: decide, write back ----------------
  assign s1_addr     = s1.id[AW-1:0];
  assign s1_in_range = ({1'b0, s1.id} < SLOTS_V);

  // newest copy of the slot: bypass beats RAM, unwritten slot is idle
  always_comb begin
    cur_rec      = rd_data;
    cur_rec.mode = trrf_pkg::MODE_IDLE;
    if (fwd_valid && fwd_addr == s1_addr) begin
      cur_rec = fwd_rec;
    end else if (s1_in_range && seen[s1_addr]) begin
      cur_rec = rd_data;
    end
  end

  assign cur_mode = cur_rec.mode;

  always_comb begin
    logic [1:0] new_mode;
    logic       do_wr;
    new_mode = trrf_pkg::MODE_IDLE;
    do_wr    = 1'b0;
    rep      = 1'b1;
    priority if (s1.release_b) begin
      rep      = 1'b0;
      do_wr    = s1_in_range;
      new_mode = trrf_pkg::MODE_IDLE;
    end else if (!s1_in_range) begin
      rep = 1'b1;
    end else if (cur_mode == trrf_pkg::MODE_PASS) begin
      rep = 1'b1;
    end else if (!s1.hit) begin
      rep      = 1'b1;
      do_wr    = 1'b1;
      new_mode = trrf_pkg::MODE_PASS;
    end else if (cur_mode == trrf_pkg::MODE_IDLE) begin
      // first matching report: latch position, hold
      rep      = 1'b0;
      do_wr    = 1'b1;
      new_mode = trrf_pkg::MODE_HELD;
    end else if (cur_rec.x == s1.x && cur_rec.y == s1.y) begin
      rep = 1'b0;   // repeat at the held spot
    end else begin
      rep      = 1'b1;
      do_wr    = 1'b1;
      new_mode = trrf_pkg::MODE_PASS;
    end

    wr_en       = s1_valid && advance && do_wr;
    wr_addr     = s1_addr;
    wr_rec.mode = new_mode;
    wr_rec.x    = s1.x;
    wr_rec.y    = s1.y;
    // moving to passing keeps the old spot; only hold latches a new one
    if (new_mode != trrf_pkg::MODE_HELD) begin
      wr_rec.x = cur_rec.x;
      wr_rec.y = cur_rec.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      seen[wr_addr] <= 1'b1;
      fwd_valid     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_rec  <= wr_rec;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tuser <= rep;
      m_tdata <= {4'd0, s1.id};
    end
  end

`ifndef SYNTHESIS
  // the input side only stalls when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled without a full pipeline");

  // slot state is never written for an out-of-range slot
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_in_range)
    else $error("slot RAM write outside slot range");

  // a release never produces a forwarded report
  a_release_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1.release_b) |=> !m_tuser)
    else $error("release forwarded as a report");
`endif

endmodule

// ===== rtl/trrf_ram.sv =====
module trrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
